// ===== hdl/pfrl_pkg.sv =====
package pfrl_pkg;

    localparam int TableSlotsDefault = 16;
    localparam logic [15:0] RateLimitReset = 16'd100;
    localparam logic [10:0] OffMax = 11'd2047;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_SLOT  = 2'd1;
    localparam logic [1:0] CMD_STAT  = 2'd2;

    localparam logic [1:0] ACT_LIMIT = 2'd1;
    localparam logic [1:0] ACT_DROP  = 2'd2;

    localparam logic [1:0] STAT_TOTAL   = 2'd0;
    localparam logic [1:0] STAT_DROPPED = 2'd1;
    localparam logic [1:0] STAT_LIMITED = 2'd2;

    localparam int InWidth  = 136;
    localparam int OutWidth = 240;

    // Work handed from the parser to the back end.
    typedef struct packed {
        logic        is_stat;
        logic [1:0]  stat_index;
        logic        is_slot;
        logic [3:0]  slot_index;
        logic        slot_enable;
        logic [31:0] entry_key;
        logic [1:0]  entry_action;
        logic        entry_has_counter;
        logic [15:0] entry_count;
        logic        analysed;
        logic        l4_ok;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_l4;
        logic [15:0] dst_l4;
        logic [7:0]  protocol;
        logic [5:0]  flag_bits;
        logic [15:0] ip_length;
        logic [63:0] time_stamp;
    } job_t;

    typedef struct packed {
        logic [47:0] stat_value;
        logic [63:0] ev_time;
        logic [15:0] ev_ip_length;
        logic [5:0]  ev_flag_bits;
        logic [7:0]  ev_protocol;
        logic [15:0] ev_dst_l4;
        logic [15:0] ev_src_l4;
        logic [31:0] ev_dst_ip;
        logic [31:0] ev_src_ip;
        logic        event_valid;
        logic        frame_drop;
    } result_t;

endpackage

// ===== hdl/packet_filter_rate_limiter.sv =====
// Channel   Direction  Contents
// s_axis    in         command, frame byte, slot write or statistic request
// m_axis    out        frame verdict with event record, or statistic value
// cfg       in         rate_limit register write
// One transaction is accepted per cycle while s_axis_tready is high; a result is registered
// first in the two-entry queue and then in the output register of the table stage before
// it is offered on m_axis.
// Slot writes travel through the queue, so they take effect in input order.
// Reset is synchronous and clears the frame parser, table valid bits and statistics.
// A stalled output fills the queue, after which s_axis_tready falls.
module packet_filter_rate_limiter #(
    parameter int TABLE_SLOTS = pfrl_pkg::TableSlotsDefault
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // cmd, data_byte, last_byte, arrival_time, slot_index, slot_enable, entry_key,
    // entry_action, entry_has_counter, entry_count, stat_index
    input  logic [pfrl_pkg::InWidth-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // frame_drop, event_valid, ev_src_ip, ev_dst_ip, source port, destination port,
    // ev_protocol, flag bits, ev_ip_length, ev_time, stat_value
    output logic [pfrl_pkg::OutWidth-1:0] m_axis_tdata,
    // result_kind
    output logic                          m_axis_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [15:0]                   cfg_data
);
    import pfrl_pkg::*;

    logic [15:0] rate_limit_reg;
    logic        acc;
    logic        pj_valid, q_ready, q_valid, e_ready;
    job_t        pj, qj;
    result_t     res;
    logic [1:0]  cmd;

    assign cmd           = s_axis_tdata[1:0];
    assign s_axis_tready = q_ready;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) rate_limit_reg <= RateLimitReset;
        else if (cfg_valid) rate_limit_reg <= cfg_data;
    end

    pfrl_parser u_parser (
        .aclk, .aresetn,
        .in_valid          (acc),
        .cmd               (cmd),
        .data_byte         (s_axis_tdata[9:2]),
        .last_byte         (s_axis_tdata[10]),
        .arrival_time      (s_axis_tdata[74:11]),
        .slot_index        (s_axis_tdata[78:75]),
        .slot_enable       (s_axis_tdata[79]),
        .entry_key         (s_axis_tdata[111:80]),
        .entry_action      (s_axis_tdata[113:112]),
        .entry_has_counter (s_axis_tdata[114]),
        .entry_count       (s_axis_tdata[130:115]),
        .stat_index        (s_axis_tdata[132:131]),
        .job_valid         (pj_valid),
        .job               (pj)
    );

    pfrl_queue u_queue (
        .aclk, .aresetn,
        .wr_valid (pj_valid),
        .wr_ready (q_ready),
        .wr_job   (pj),
        .rd_valid (q_valid),
        .rd_ready (e_ready),
        .rd_job   (qj)
    );

    pfrl_engine #(.TABLE_SLOTS(TABLE_SLOTS)) u_engine (
        .aclk, .aresetn,
        .rate_limit        (rate_limit_reg),
        .job_valid         (q_valid),
        .job_ready         (e_ready),
        .job               (qj),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_res           (res),
        .out_kind          (m_axis_tuser)
    );

    assign m_axis_tdata = res;
endmodule

// ===== hdl/pfrl_parser.sv =====
module pfrl_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [1:0]           cmd,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [63:0]          arrival_time,
    input  logic [3:0]           slot_index,
    input  logic                 slot_enable,
    input  logic [31:0]          entry_key,
    input  logic [1:0]           entry_action,
    input  logic                 entry_has_counter,
    input  logic [15:0]          entry_count,
    input  logic [1:0]           stat_index,
    output logic                 job_valid,
    output pfrl_pkg::job_t       job
);
    import pfrl_pkg::*;

    logic [10:0] off_reg, off_next;
    logic [15:0] etype_reg, etype_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [7:0]  proto_reg, proto_next;
    logic [63:0] addr_reg, addr_next;
    logic [39:0] l4_reg, l4_next;
    logic [11:0] l4_start;
    logic [11:0] off_w;
    logic [11:0] len;
    logic [11:0] rel;

    always_comb begin
        off_next   = off_reg;
        etype_next = etype_reg;
        ihl_next   = ihl_reg;
        tlen_next  = tlen_reg;
        proto_next = proto_reg;
        addr_next  = addr_reg;
        l4_next    = l4_reg;
        off_w      = {1'b0, off_reg};
        len        = off_w + 12'd1;
        job_valid  = 1'b0;
        job        = '0;
        l4_start   = '0;
        rel        = '0;
        if (in_valid && cmd == CMD_STAT) begin
            job_valid      = 1'b1;
            job.is_stat    = 1'b1;
            job.stat_index = stat_index;
        end else if (in_valid && cmd == CMD_SLOT) begin
            job_valid             = 1'b1;
            job.is_slot           = 1'b1;
            job.slot_index        = slot_index;
            job.slot_enable       = slot_enable;
            job.entry_key         = entry_key;
            job.entry_action      = entry_action;
            job.entry_has_counter = entry_has_counter;
            job.entry_count       = entry_count;
        end else if (in_valid && cmd == CMD_BYTE) begin
            if (off_reg == 11'd12) etype_next[15:8] = data_byte;
            if (off_reg == 11'd13) etype_next[7:0] = data_byte;
            if (off_reg == 11'd14) ihl_next = data_byte[3:0];
            if (off_reg == 11'd16) tlen_next[15:8] = data_byte;
            if (off_reg == 11'd17) tlen_next[7:0] = data_byte;
            if (off_reg == 11'd23) proto_next = data_byte;
            if (off_reg >= 11'd26 && off_reg <= 11'd33)
                addr_next[8 * (33 - off_reg[5:0]) +: 8] = data_byte;
            l4_start = 12'd14 + {6'd0, ihl_next, 2'b00};
            rel = off_w - l4_start;
            if (off_w >= l4_start && rel <= 12'd3)
                l4_next[8 + 8 * (3 - rel[1:0]) +: 8] = data_byte;
            else if (off_w == l4_start + 12'd13)
                l4_next[7:0] = data_byte;
            if (!last_byte) begin
                if (off_reg < OffMax) off_next = off_reg + 11'd1;
            end else begin
                job_valid      = 1'b1;
                job.analysed   = (len >= 12'd34) && (etype_next == 16'h0800);
                job.l4_ok      = (proto_next == 8'd6 && len >= l4_start + 12'd20) ||
                                 (proto_next == 8'd17 && len >= l4_start + 12'd8);
                job.src_ip     = addr_next[63:32];
                job.dst_ip     = addr_next[31:0];
                job.src_l4     = l4_next[39:24];
                job.dst_l4     = l4_next[23:8];
                job.protocol   = proto_next;
                job.flag_bits  = (proto_next == 8'd6) ? l4_next[5:0] : 6'd0;
                job.ip_length  = tlen_next;
                job.time_stamp = arrival_time;
                off_next   = '0;
                etype_next = '0;
                ihl_next   = '0;
                tlen_next  = '0;
                proto_next = '0;
                addr_next  = '0;
                l4_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg   <= '0;
            etype_reg <= '0;
            ihl_reg   <= '0;
            tlen_reg  <= '0;
            proto_reg <= '0;
            addr_reg  <= '0;
            l4_reg    <= '0;
        end else begin
            off_reg   <= off_next;
            etype_reg <= etype_next;
            ihl_reg   <= ihl_next;
            tlen_reg  <= tlen_next;
            proto_reg <= proto_next;
            addr_reg  <= addr_next;
            l4_reg    <= l4_next;
        end
    end
endmodule

// ===== hdl/pfrl_queue.sv =====
module pfrl_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  pfrl_pkg::job_t       wr_job,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output pfrl_pkg::job_t       rd_job
);
    import pfrl_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_valid && wr_ready) mem_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr_valid && wr_ready) wp_reg <= ~wp_reg;
            if (rd_valid && rd_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
        end
    end
endmodule

// ===== hdl/pfrl_engine.sv =====
module pfrl_engine #(
    parameter int TABLE_SLOTS = pfrl_pkg::TableSlotsDefault
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          rate_limit,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  pfrl_pkg::job_t       job,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pfrl_pkg::result_t    out_res,
    output logic                 out_kind
);
    import pfrl_pkg::*;

    localparam int IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    logic [TABLE_SLOTS-1:0] valid_reg, cval_reg;
    logic [31:0] key_reg [TABLE_SLOTS];
    logic [1:0]  act_reg [TABLE_SLOTS];
    logic [15:0] count_reg [TABLE_SLOTS];
    logic [47:0] stat_reg [3];

    logic [TABLE_SLOTS-1:0] hit;
    logic        found;
    logic [IdxW-1:0] sel;
    logic        drop, bump_limit;
    logic        take;
    logic        slot_wr;
    logic [IdxW-1:0] widx;
    result_t     res;

    always_comb begin
        for (int i = 0; i < TABLE_SLOTS; i++)
            hit[i] = valid_reg[i] && key_reg[i] == job.src_ip;
        found = 1'b0;
        sel   = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found = 1'b1;
                sel   = IdxW'(i);
            end
        end
    end

    assign job_ready = !out_valid || out_ready;
    assign take      = job_valid && job_ready;
    assign slot_wr   = take && job.is_slot && 32'(job.slot_index) < TABLE_SLOTS;
    assign widx      = IdxW'(job.slot_index);

    always_comb begin
        drop       = 1'b0;
        bump_limit = 1'b0;
        res        = '0;
        if (job.is_stat) begin
            unique case (job.stat_index)
                STAT_TOTAL:   res.stat_value = stat_reg[0];
                STAT_DROPPED: res.stat_value = stat_reg[1];
                STAT_LIMITED: res.stat_value = stat_reg[2];
                default:      res.stat_value = '0;
            endcase
        end else if (job.analysed) begin
            if (found && act_reg[sel] == ACT_DROP) begin
                drop = 1'b1;
            end else if (found && act_reg[sel] == ACT_LIMIT && cval_reg[sel] &&
                         count_reg[sel] > rate_limit) begin
                drop       = 1'b1;
                bump_limit = 1'b1;
            end
            res.frame_drop = drop;
            if (!drop && job.l4_ok) begin
                res.event_valid  = 1'b1;
                res.ev_src_ip    = job.src_ip;
                res.ev_dst_ip    = job.dst_ip;
                res.ev_src_l4    = job.src_l4;
                res.ev_dst_l4    = job.dst_l4;
                res.ev_protocol  = job.protocol;
                res.ev_flag_bits = job.flag_bits;
                res.ev_ip_length = job.ip_length;
                res.ev_time      = job.time_stamp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_wr) begin
            key_reg[widx]   <= job.entry_key;
            act_reg[widx]   <= job.entry_action;
            count_reg[widx] <= job.entry_count;
        end else if (take && !job.is_stat && !job.is_slot && job.analysed && found &&
                     act_reg[sel] == ACT_LIMIT && cval_reg[sel] && !drop &&
                     count_reg[sel] != 16'hFFFF) begin
            count_reg[sel] <= count_reg[sel] + 16'd1;
        end
        if (take && !job.is_slot) begin
            out_res  <= res;
            out_kind <= job.is_stat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            cval_reg  <= '0;
            stat_reg  <= '{default: '0};
            out_valid <= 1'b0;
        end else begin
            if (slot_wr) begin
                valid_reg[widx] <= job.slot_enable;
                cval_reg[widx]  <= job.entry_has_counter;
            end
            if (take && !job.is_stat && !job.is_slot && job.analysed) begin
                stat_reg[0] <= stat_reg[0] + 48'd1;
                if (drop && !bump_limit) stat_reg[1] <= stat_reg[1] + 48'd1;
                if (bump_limit) stat_reg[2] <= stat_reg[2] + 48'd1;
            end
            if (take && !job.is_slot) out_valid <= 1'b1;
            else if (out_ready) out_valid <= 1'b0;
        end
    end
endmodule

// ===== hdl/pfrl_checker.sv =====
module pfrl_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [239:0] m_axis_tdata,
    input logic         m_axis_tuser
);
    a_stat_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[191:0] == '0)
        else $error("statistic result carries verdict bits");
    a_drop_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser && m_axis_tdata[0] |-> !m_axis_tdata[1])
        else $error("dropped frame has an event");
    a_verdict_nostat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[239:192] == '0)
        else $error("verdict carries a statistic");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
endmodule

bind packet_filter_rate_limiter pfrl_checker u_checker (
    .aclk, .aresetn, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
